// File: sv/assert_macros.svh
// Assertion macros shared by the responder RTL.
// Define ASSERT_OFF to compile every check away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, disabled in reset.
`define ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: %m");
// Next-cycle implication, disabled in reset.
`define ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: %m");
`else
`define ASSERT_IMP(lbl, clk, rst, ante, cons)
`define ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

// File: sv/rhub_pkg.sv
// Types, codes, descriptor tables and microcode for the root hub responder.
// No dependencies; used by the top and decode modules.
`default_nettype none
package rhub_pkg;

  localparam int MaxBytes = 42;
  typedef logic [5:0] len_t;

  // func codes
  localparam logic [1:0] FUNC_REQUEST = 2'd0;
  localparam logic [1:0] FUNC_ATTACH  = 2'd1;
  localparam logic [1:0] FUNC_DETACH  = 2'd2;

  // {bRequest, bmRequestType}
  localparam logic [15:0] KEY_GET_STATUS_DEV = 16'h0080;
  localparam logic [15:0] KEY_GET_STATUS_IF  = 16'h0081;
  localparam logic [15:0] KEY_GET_STATUS_EP  = 16'h0082;
  localparam logic [15:0] KEY_GET_STATUS_HUB = 16'h00A0;
  localparam logic [15:0] KEY_GET_STATUS_PRT = 16'h00A3;
  localparam logic [15:0] KEY_CLR_FEAT_EP    = 16'h0102;
  localparam logic [15:0] KEY_CLR_FEAT_HUB   = 16'h0120;
  localparam logic [15:0] KEY_CLR_FEAT_PRT   = 16'h0123;
  localparam logic [15:0] KEY_SET_FEAT_PRT   = 16'h0323;
  localparam logic [15:0] KEY_SET_ADDRESS    = 16'h0500;
  localparam logic [15:0] KEY_GET_DESC       = 16'h0680;
  localparam logic [15:0] KEY_GET_HUB_DESC   = 16'h06A0;
  localparam logic [15:0] KEY_GET_CONFIG     = 16'h0880;
  localparam logic [15:0] KEY_SET_CONFIG     = 16'h0900;

  // port feature selectors
  localparam logic [15:0] FEAT_ENABLE   = 16'd1;
  localparam logic [15:0] FEAT_SUSPEND  = 16'd2;
  localparam logic [15:0] FEAT_RESET    = 16'd4;
  localparam logic [15:0] FEAT_POWER    = 16'd8;
  localparam logic [15:0] FEAT_C_CONN   = 16'd16;
  localparam logic [15:0] FEAT_C_ENABLE = 16'd17;
  localparam logic [15:0] FEAT_C_SUSP   = 16'd18;
  localparam logic [15:0] FEAT_C_OVERCR = 16'd19;
  localparam logic [15:0] FEAT_C_RESET  = 16'd20;

  // descriptor types and string indexes
  localparam logic [7:0] DESC_DEVICE = 8'd1;
  localparam logic [7:0] DESC_CONFIG = 8'd2;
  localparam logic [7:0] DESC_STRING = 8'd3;
  localparam logic [7:0] STR_LANG    = 8'd0;
  localparam logic [7:0] STR_SERIAL  = 8'd1;
  localparam logic [7:0] STR_PRODUCT = 8'd2;

  // port status / change bits
  localparam logic [15:0] ST_CONN     = 16'h0001;
  localparam logic [15:0] ST_ENABLE   = 16'h0002;
  localparam logic [15:0] ST_SUSPEND  = 16'h0004;
  localparam logic [15:0] ST_POWER    = 16'h0100;
  localparam logic [15:0] ST_LOWSPEED = 16'h0200;
  localparam logic [15:0] CH_CONN     = 16'h0001;
  localparam logic [15:0] CH_ENABLE   = 16'h0002;
  localparam logic [15:0] CH_SUSPEND  = 16'h0004;
  localparam logic [15:0] CH_OVERCUR  = 16'h0008;
  localparam logic [15:0] CH_RESET    = 16'h0010;

  // descriptor lengths
  localparam len_t LEN_DEVICE  = 6'd18;
  localparam len_t LEN_CONFIG  = 6'd25;
  localparam len_t LEN_HUB     = 6'd9;
  localparam len_t LEN_LANG    = 6'd4;
  localparam len_t LEN_SERIAL  = 6'd4;
  localparam len_t LEN_PRODUCT = 6'd42;
  localparam len_t LEN_MAX     = len_t'(MaxBytes);

  typedef enum logic [3:0] {
    SRC_ZERO, SRC_ONE, SRC_PORT, SRC_DEV, SRC_CFG, SRC_HUB,
    SRC_LANG, SRC_SERIAL, SRC_PRODUCT
  } src_t;

  typedef struct packed {
    logic [1:0]  func;
    logic        attach_low_speed;
    logic        interrupt_pipe;
    logic [7:0]  request_type;
    logic [7:0]  request_code;
    logic [15:0] setup_value;
    logic [15:0] requested_length;
    logic [15:0] buffer_length;
  } req_t;

  // decode result: response shape plus updated hub state
  typedef struct packed {
    src_t        src;
    len_t        len;
    logic        stall;
    logic        no_result;
    logic [15:0] port_state;
    logic [15:0] port_changes;
    logic [15:0] address;
  } dec_t;

  // sequencer
  typedef enum logic [1:0] {STEP_FETCH, STEP_DECODE, STEP_EMIT} step_t;
  typedef enum logic [1:0] {COND_REQ_ACCEPT, COND_NO_RESULT, COND_LAST_SENT} cond_t;

  typedef struct packed {
    logic  take_req;   // open the request channel
    logic  latch_dec;  // register decode, commit hub state
    logic  emit;       // push one response word
    cond_t cond;       // jump condition
    step_t target;     // jump target
    logic  seq_else;   // advance to next step when no jump
  } ucode_t;

  function automatic ucode_t ucode_rom(step_t s);
    ucode_t w;
    case (s)
      STEP_FETCH:  w = '{1'b1, 1'b0, 1'b0, COND_REQ_ACCEPT, STEP_DECODE, 1'b0};
      STEP_DECODE: w = '{1'b0, 1'b1, 1'b0, COND_NO_RESULT, STEP_FETCH, 1'b1};
      STEP_EMIT:   w = '{1'b0, 1'b0, 1'b1, COND_LAST_SENT, STEP_FETCH, 1'b0};
      default:     w = '{1'b0, 1'b0, 1'b0, COND_NO_RESULT, STEP_FETCH, 1'b0};
    endcase
    return w;
  endfunction

  function automatic logic [7:0] dev_byte(logic [4:0] i);
    logic [7:0] b;
    case (i)
      5'd0: b = 8'h12;  5'd1: b = 8'h01;  5'd2: b = 8'h10;  5'd3: b = 8'h01;
      5'd4: b = 8'h09;  5'd7: b = 8'h08;  5'd15: b = 8'h02; 5'd16: b = 8'h01;
      5'd17: b = 8'h01;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] cfg_byte(logic [4:0] i);
    logic [7:0] b;
    case (i)
      5'd0: b = 8'h09;  5'd1: b = 8'h02;  5'd2: b = 8'h19;  5'd4: b = 8'h01;
      5'd5: b = 8'h01;  5'd7: b = 8'h40;  5'd9: b = 8'h09;  5'd10: b = 8'h04;
      5'd13: b = 8'h01; 5'd14: b = 8'h09; 5'd18: b = 8'h07; 5'd19: b = 8'h05;
      5'd20: b = 8'h81; 5'd21: b = 8'h03; 5'd22: b = 8'h08; 5'd24: b = 8'hff;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] hub_byte(logic [3:0] i);
    logic [7:0] b;
    case (i)
      4'd0: b = 8'h09; 4'd1: b = 8'h29; 4'd2: b = 8'h01; 4'd5: b = 8'h50;
      4'd7: b = 8'hfc; 4'd8: b = 8'hff;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  // product text, one ASCII character per index
  function automatic logic [7:0] product_char(logic [4:0] c);
    logic [7:0] b;
    case (c)
      5'd0: b = 8'h55;  5'd1: b = 8'h53;  5'd2: b = 8'h42;  5'd3: b = 8'h20;
      5'd4: b = 8'h53;  5'd5: b = 8'h4C;  5'd6: b = 8'h38;  5'd7: b = 8'h31;
      5'd8: b = 8'h31;  5'd9: b = 8'h48;  5'd10: b = 8'h53; 5'd11: b = 8'h20;
      5'd12: b = 8'h52; 5'd13: b = 8'h6F; 5'd14: b = 8'h6F; 5'd15: b = 8'h74;
      5'd16: b = 8'h20; 5'd17: b = 8'h48; 5'd18: b = 8'h75; 5'd19: b = 8'h62;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  // Response byte at index i of the selected source.
  function automatic logic [7:0] src_byte(src_t src, len_t i,
                                          logic [15:0] pstate, logic [15:0] pchg);
    logic [7:0] b;
    len_t       k;
    k = i - 6'd2;
    b = 8'h00;
    case (src)
      SRC_ONE:  b = (i == 6'd0) ? 8'h01 : 8'h00;
      SRC_PORT: begin
        case (i)
          6'd0: b = pstate[7:0];
          6'd1: b = pstate[15:8];
          6'd2: b = pchg[7:0];
          6'd3: b = pchg[15:8];
          default: b = 8'h00;
        endcase
      end
      SRC_DEV: b = dev_byte(i[4:0]);
      SRC_CFG: b = cfg_byte(i[4:0]);
      SRC_HUB: b = hub_byte(i[3:0]);
      SRC_LANG, SRC_SERIAL, SRC_PRODUCT: begin
        if (i == 6'd0) begin
          b = (src == SRC_PRODUCT) ? 8'(LEN_PRODUCT) : 8'h04;
        end else if (i == 6'd1) begin
          b = DESC_STRING;
        end else if (!i[0]) begin
          case (src)
            SRC_SERIAL:  b = 8'h30;
            SRC_PRODUCT: b = product_char(k[5:1]);
            default:     b = 8'h00;
          endcase
        end
      end
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage
`default_nettype wire

// File: sv/rhub_if.sv
// Valid/ready channel interfaces for the responder's request and response words.
// Has no dependencies.
`default_nettype none
interface rhub_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic        attach_low_speed;
  logic        interrupt_pipe;
  logic [7:0]  request_type;
  logic [7:0]  request_code;
  logic [15:0] setup_value;
  logic [15:0] requested_length;
  logic [15:0] buffer_length;

  modport source (output valid, func, attach_low_speed, interrupt_pipe, request_type,
                  request_code, setup_value, requested_length, buffer_length,
                  input ready);
  modport sink (input valid, func, attach_low_speed, interrupt_pipe, request_type,
                request_code, setup_value, requested_length, buffer_length,
                output ready);
endinterface

interface rhub_rsp_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic        byte_valid;
  logic        last;
  logic        stalled;
  logic [5:0]  actual_length;
  logic [15:0] current_address;

  modport source (output valid, data_byte, byte_valid, last, stalled, actual_length,
                  current_address, input ready);
  modport sink (input valid, data_byte, byte_valid, last, stalled, actual_length,
                current_address, output ready);
endinterface
`default_nettype wire

// File: sv/usb_root_hub_request_responder_top.sv
// Top level of the single-port root hub request responder.
// Depends on rhub_pkg, rhub_if (channel interfaces), rhub_decode, assert_macros.svh.
//
// Usage:
//   req  - request/event words in: func selects control request, attach or
//          detach; the setup fields and buffer length ride along.
//   rsp  - response words out, one per response byte; a request that
//          returns no bytes (stall, empty answer, zero buffer, interrupt
//          pipe) gives one word with byte_valid low and last high.
//   A small microcode ROM runs three steps: fetch (req ready), decode
//   (commit port status, change and address), emit (one word per cycle
//   while rsp is not stalled). The decode step registers the decoded
//   shape; the emit step then loads the response register. A request
//   returns at most 42 bytes. Attach and detach give no response word.
//   The response register decouples the sides: while the final word waits,
//   the next request is already accepted. A stall on rsp holds the emit
//   step and the current word.
//   Reset (rst, synchronous) clears port status, change bits and address,
//   drops any word in flight and returns the sequencer to fetch; req ready
//   stays low while rst is high.
`default_nettype none
`include "assert_macros.svh"
module usb_root_hub_request_responder_top (
  input  logic       clk,
  input  logic       rst,
  rhub_req_if.sink   req,
  rhub_rsp_if.source rsp
);
  import rhub_pkg::*;

  step_t       step;
  step_t       step_next;
  ucode_t      uc;
  req_t        req_q;
  dec_t        dec;
  dec_t        dec_q;
  len_t        idx;
  logic [15:0] port_state;
  logic [15:0] port_changes;
  logic [15:0] device_address;
  logic        req_acc;
  logic        emit_load;
  logic        last_word;
  logic        jump;

  // response register
  logic        out_valid;
  logic [7:0]  out_data;
  logic        out_byte_valid;
  logic        out_last;
  logic        out_stalled;
  len_t        out_len;
  logic [15:0] out_addr;

  assign uc        = ucode_rom(step);
  // hold off requests while in reset
  assign req.ready = uc.take_req && !rst;
  assign req_acc   = req.valid && req.ready;

  // emit only when the response register is free or being drained
  assign emit_load = uc.emit && (!out_valid || rsp.ready);
  assign last_word = (dec_q.len == '0) || (idx == dec_q.len - 6'd1);

  rhub_decode u_decode (
    .req            (req_q),
    .port_state     (port_state),
    .port_changes   (port_changes),
    .device_address (device_address),
    .dec            (dec)
  );

  // sequencer: step register and jump logic
  always_ff @(posedge clk) begin
    if (rst) begin
      step <= STEP_FETCH;
    end else begin
      step <= step_next;
    end
  end

  always_comb begin
    case (uc.cond)
      COND_REQ_ACCEPT: jump = req_acc;
      COND_NO_RESULT:  jump = dec.no_result;
      COND_LAST_SENT:  jump = emit_load && last_word;
      default:         jump = 1'b0;
    endcase
    if (jump) begin
      step_next = uc.target;
    end else if (uc.seq_else) begin
      step_next = step_t'(step + 2'd1);
    end else begin
      step_next = step;
    end
  end

  // capture the request word
  always_ff @(posedge clk) begin
    if (req_acc) begin
      req_q.func             <= req.func;
      req_q.attach_low_speed <= req.attach_low_speed;
      req_q.interrupt_pipe   <= req.interrupt_pipe;
      req_q.request_type     <= req.request_type;
      req_q.request_code     <= req.request_code;
      req_q.setup_value      <= req.setup_value;
      req_q.requested_length <= req.requested_length;
      req_q.buffer_length    <= req.buffer_length;
    end
  end

  // hub state commits in the decode step
  always_ff @(posedge clk) begin
    if (rst) begin
      port_state     <= '0;
      port_changes   <= '0;
      device_address <= '0;
    end else if (uc.latch_dec) begin
      port_state     <= dec.port_state;
      port_changes   <= dec.port_changes;
      device_address <= dec.address;
    end
  end

  // hold the decoded shape and walk the byte index
  always_ff @(posedge clk) begin
    if (uc.latch_dec) begin
      dec_q <= dec;
      idx   <= '0;
    end else if (emit_load) begin
      idx <= idx + 6'd1;
    end
  end

  // response register: load a word or drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_load) begin
      out_data       <= (dec_q.len == '0) ? 8'h00
                        : src_byte(dec_q.src, idx, port_state, port_changes);
      out_byte_valid <= (dec_q.len != '0);
      out_last       <= last_word;
      out_stalled    <= dec_q.stall;
      out_len        <= dec_q.len;
      out_addr       <= device_address;
    end
  end

  assign rsp.valid           = out_valid;
  assign rsp.data_byte       = out_data;
  assign rsp.byte_valid      = out_byte_valid;
  assign rsp.last            = out_last;
  assign rsp.stalled         = out_stalled;
  assign rsp.actual_length   = out_len;
  assign rsp.current_address = out_addr;

  `ASSERT_NXT(a_accept_to_decode, clk, rst, req_acc, step == STEP_DECODE)
  `ASSERT_IMP(a_no_take_in_emit, clk, rst, step == STEP_EMIT, !req.ready)
  `ASSERT_IMP(a_idx_in_range, clk, rst, (step == STEP_EMIT) && (dec_q.len != '0),
              idx < dec_q.len)
  `ASSERT_IMP(a_empty_has_no_len, clk, rst, out_valid && !out_byte_valid,
              (out_len == '0) && out_last)
  `ASSERT_IMP(a_stall_is_empty, clk, rst, out_valid && out_stalled, !out_byte_valid)

endmodule
`default_nettype wire

// File: sv/rhub_decode.sv
// Request decoder: maps a latched request and the hub state to a response
// shape and the updated state. Depends on rhub_pkg.
`default_nettype none
module rhub_decode (
  input  rhub_pkg::req_t      req,
  input  logic [15:0]         port_state,
  input  logic [15:0]         port_changes,
  input  logic [15:0]         device_address,
  output rhub_pkg::dec_t      dec
);
  import rhub_pkg::*;

  logic [15:0] key;
  len_t        base_len;
  len_t        str_len;
  logic        is_string;
  logic        stall;
  src_t        src;
  logic [15:0] ps;
  logic [15:0] pc;
  logic [15:0] addr;

  assign key = {req.request_code, req.request_type};

  always_comb begin
    ps        = port_state;
    pc        = port_changes;
    addr      = device_address;
    src       = SRC_ZERO;
    base_len  = '0;
    is_string = 1'b0;
    stall     = 1'b0;

    case (req.func)
      FUNC_ATTACH: begin
        ps = (port_state | ST_CONN) & ~ST_LOWSPEED;
        if (req.attach_low_speed) ps = ps | ST_LOWSPEED;
        pc = port_changes | CH_CONN;
      end
      FUNC_DETACH: begin
        ps = port_state & ~(ST_CONN | ST_ENABLE);
        pc = port_changes | CH_CONN;
      end
      FUNC_REQUEST: begin
        if (!req.interrupt_pipe) begin
          case (key)
            KEY_GET_STATUS_DEV: begin src = SRC_ONE; base_len = 6'd2; end
            KEY_GET_STATUS_IF, KEY_GET_STATUS_EP: base_len = 6'd2;
            KEY_GET_STATUS_HUB: base_len = 6'd4;
            KEY_GET_STATUS_PRT: begin src = SRC_PORT; base_len = 6'd4; end
            KEY_CLR_FEAT_EP, KEY_CLR_FEAT_HUB, KEY_SET_CONFIG: ;
            KEY_CLR_FEAT_PRT: begin
              case (req.setup_value)
                FEAT_ENABLE:   ps = port_state & ~ST_ENABLE;
                FEAT_SUSPEND:  ps = port_state & ~ST_SUSPEND;
                FEAT_POWER:    ps = port_state & ~ST_POWER;
                FEAT_C_CONN:   pc = port_changes & ~CH_CONN;
                FEAT_C_ENABLE: pc = port_changes & ~CH_ENABLE;
                FEAT_C_SUSP:   pc = port_changes & ~CH_SUSPEND;
                FEAT_C_OVERCR: pc = port_changes & ~CH_OVERCUR;
                FEAT_C_RESET:  pc = port_changes & ~CH_RESET;
                default: ;
              endcase
            end
            KEY_SET_FEAT_PRT: begin
              case (req.setup_value)
                FEAT_ENABLE:  ps = port_state | ST_ENABLE;
                FEAT_SUSPEND: ps = port_state | ST_SUSPEND;
                FEAT_RESET: begin
                  pc = CH_RESET;
                  ps = port_state | ST_ENABLE;
                end
                FEAT_POWER:   ps = port_state | ST_POWER;
                default: ;
              endcase
            end
            KEY_SET_ADDRESS: addr = req.setup_value;
            KEY_GET_DESC: begin
              case (req.setup_value[15:8])
                DESC_DEVICE: begin src = SRC_DEV; base_len = LEN_DEVICE; end
                DESC_CONFIG: begin src = SRC_CFG; base_len = LEN_CONFIG; end
                DESC_STRING: begin
                  is_string = 1'b1;
                  case (req.setup_value[7:0])
                    STR_LANG:    begin src = SRC_LANG;    base_len = LEN_LANG;    end
                    STR_SERIAL:  begin src = SRC_SERIAL;  base_len = LEN_SERIAL;  end
                    STR_PRODUCT: begin src = SRC_PRODUCT; base_len = LEN_PRODUCT; end
                    default:     stall = 1'b1;
                  endcase
                end
                default: stall = 1'b1;
              endcase
            end
            KEY_GET_HUB_DESC: begin src = SRC_HUB; base_len = LEN_HUB; end
            KEY_GET_CONFIG:   begin src = SRC_ONE; base_len = 6'd1; end
            default: stall = 1'b1;
          endcase
        end
      end
      default: ;
    endcase
  end

  // clip strings to wLength, then everything to the caller buffer and to LEN_MAX
  always_comb begin
    str_len = base_len;
    if (is_string && (req.requested_length < 16'(base_len)))
      str_len = req.requested_length[5:0];
    if (req.buffer_length < 16'(str_len))
      str_len = req.buffer_length[5:0];
    if (str_len > LEN_MAX)
      str_len = LEN_MAX;
  end

  always_comb begin
    dec.src          = src;
    dec.len          = stall ? '0 : str_len;
    dec.stall        = stall;
    dec.no_result    = (req.func != FUNC_REQUEST);
    dec.port_state   = ps;
    dec.port_changes = pc;
    dec.address      = addr;
  end

endmodule
`default_nettype wire
